// ===== sv/tae_pkg.sv =====
// Shared types and constants for the tilt angle estimator.
// Used by the interfaces, controller, datapath and top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tae_pkg;

    localparam int ITER_W     = 5;
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_W     = 22;
    localparam int ACC_W      = 26;
    localparam int ANGLE_W    = 16;
    localparam int SUM_W      = 20;
    localparam int MAG_W      = 18;
    localparam int RECIP_W    = 20;
    localparam int PROD_W     = MAG_W + RECIP_W;
    localparam int RECIP_SHIFT = 23;

    localparam logic [RECIP_W-1:0] RECIP_TEN = 20'd838861;
    localparam logic signed [ACC_W-9:0] ANGLE_MAX = 18'sd23040;
    localparam logic signed [ACC_W-9:0] ANGLE_MIN = -18'sd23040;

    localparam logic LANE_PITCH = 1'b0;
    localparam logic LANE_ROLL  = 1'b1;

    // atan(2^-i) in Q16 degrees, rounded to nearest
    localparam logic [ATAN_W-1:0] ATAN_Q16 [ATAN_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SQ_A,
        S_SQ_B,
        S_SQ_C,
        S_SQRT,
        S_CINIT,
        S_CORDIC,
        S_FINISH,
        S_FILT_A,
        S_FILT_B,
        S_FILT_C,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              load;
        logic              sel_pitch;
        logic              sq_a;
        logic              sq_b;
        logic              sq_c;
        logic              sqrt_step;
        logic              cord_init;
        logic              cord_step;
        logic              finish;
        logic              filt_a;
        logic              filt_b;
        logic              filt_c;
        logic              out_load;
        logic [ITER_W-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic degen;
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/tae_sample_if.sv =====
// Handshake channels of the tilt angle estimator: sample in, angles out.
// Depends on tae_pkg for the angle width.
`timescale 1ns / 1ps
`default_nettype none

interface tae_sample_if #(
    parameter int SAMPLE_BITS = 13
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink (input valid, input accel_x, input accel_y, input accel_z,
                  output ready);
endinterface

interface tae_angle_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tae_pkg::ANGLE_W-1:0]    pitch_now;
    logic signed [tae_pkg::ANGLE_W-1:0]    roll_now;
    logic signed [tae_pkg::ANGLE_W-1:0]    pitch_smoothed;
    logic signed [tae_pkg::ANGLE_W-1:0]    roll_smoothed;
    logic                                  degenerate;

    modport source (output valid, output pitch_now, output roll_now,
                    output pitch_smoothed, output roll_smoothed, output degenerate,
                    input ready);
    modport sink (input valid, input pitch_now, input roll_now,
                  input pitch_smoothed, input roll_smoothed, input degenerate,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/tae_ctrl.sv =====
// Tilt angle estimator sequencer: one datapath step a cycle; DONE can stall.
// Depends on tae_pkg (state_t, cmd_t, stat_t).
`timescale 1ns / 1ps
`default_nettype none

module tae_ctrl #(
    parameter int SAMPLE_BITS  = 13,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire tae_pkg::stat_t stat,
    output tae_pkg::cmd_t      cmd
);

    localparam logic [tae_pkg::ITER_W-1:0] SQRT_LAST =
        tae_pkg::ITER_W'(SAMPLE_BITS + 15);
    localparam logic [tae_pkg::ITER_W-1:0] CORDIC_LAST =
        tae_pkg::ITER_W'(CORDIC_STEPS - 1);

    tae_pkg::state_t             state_reg, state_next;
    logic [tae_pkg::ITER_W-1:0]  iter_reg, iter_next;
    logic                        sel_pitch_reg, sel_pitch_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        accept;
    logic                        out_load;

    assign in_ready  = (state_reg == tae_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_load  = (state_reg == tae_pkg::S_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tae_pkg::S_IDLE;
            iter_reg      <= '0;
            sel_pitch_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            sel_pitch_reg <= sel_pitch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and sequencing registers
    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        sel_pitch_next = sel_pitch_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        unique case (state_reg)
            tae_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = tae_pkg::S_CHECK;
            end
            tae_pkg::S_CHECK:
            begin
                sel_pitch_next = 1'b0;
                state_next     = stat.degen ? tae_pkg::S_FILT_A : tae_pkg::S_SQ_A;
            end
            tae_pkg::S_SQ_A:
                state_next = tae_pkg::S_SQ_B;
            tae_pkg::S_SQ_B:
                state_next = tae_pkg::S_SQ_C;
            tae_pkg::S_SQ_C:
            begin
                iter_next  = '0;
                state_next = tae_pkg::S_SQRT;
            end
            tae_pkg::S_SQRT:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == SQRT_LAST)
                    state_next = tae_pkg::S_CINIT;
            end
            tae_pkg::S_CINIT:
            begin
                iter_next  = '0;
                state_next = tae_pkg::S_CORDIC;
            end
            tae_pkg::S_CORDIC:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == CORDIC_LAST)
                    state_next = tae_pkg::S_FINISH;
            end
            tae_pkg::S_FINISH:
            begin
                if (sel_pitch_reg)
                    state_next = tae_pkg::S_FILT_A;
                else
                begin
                    sel_pitch_next = 1'b1;
                    state_next     = tae_pkg::S_SQ_A;
                end
            end
            tae_pkg::S_FILT_A:
                state_next = tae_pkg::S_FILT_B;
            tae_pkg::S_FILT_B:
                state_next = tae_pkg::S_FILT_C;
            tae_pkg::S_FILT_C:
                state_next = tae_pkg::S_DONE;
            tae_pkg::S_DONE:
            begin
                if (out_load)
                    state_next = tae_pkg::S_IDLE;
            end
            default:
                state_next = tae_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.load      = accept;
        cmd.sel_pitch = sel_pitch_reg;
        cmd.iter      = iter_reg;
        cmd.out_load  = out_load;
        unique case (state_reg)
            tae_pkg::S_SQ_A:   cmd.sq_a      = 1'b1;
            tae_pkg::S_SQ_B:   cmd.sq_b      = 1'b1;
            tae_pkg::S_SQ_C:   cmd.sq_c      = 1'b1;
            tae_pkg::S_SQRT:   cmd.sqrt_step = 1'b1;
            tae_pkg::S_CINIT:  cmd.cord_init = 1'b1;
            tae_pkg::S_CORDIC: cmd.cord_step = 1'b1;
            tae_pkg::S_FINISH: cmd.finish    = 1'b1;
            tae_pkg::S_FILT_A: cmd.filt_a    = 1'b1;
            tae_pkg::S_FILT_B: cmd.filt_b    = 1'b1;
            tae_pkg::S_FILT_C: cmd.filt_c    = 1'b1;
            default:           cmd.load      = accept;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/tae_dp.sv =====
// Datapath of the tilt angle estimator: squarer, digit-by-digit square root,
// CORDIC vectoring, angle rounding and the two low-pass filter lanes.
// Depends on tae_pkg (cmd_t, stat_t, arctangent table, filter constants).
`timescale 1ns / 1ps
`default_nettype none

module tae_dp #(
    parameter int SAMPLE_BITS = 13
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire tae_pkg::cmd_t                        cmd,
    output tae_pkg::stat_t                            stat,
    input  wire logic signed [SAMPLE_BITS-1:0]        accel_x,
    input  wire logic signed [SAMPLE_BITS-1:0]        accel_y,
    input  wire logic signed [SAMPLE_BITS-1:0]        accel_z,
    output logic signed [tae_pkg::ANGLE_W-1:0]        pitch_now,
    output logic signed [tae_pkg::ANGLE_W-1:0]        roll_now,
    output logic signed [tae_pkg::ANGLE_W-1:0]        pitch_smoothed,
    output logic signed [tae_pkg::ANGLE_W-1:0]        roll_smoothed,
    output logic                                      degenerate
);

    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int ROOT_W = SAMPLE_BITS + 16;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int VW     = SAMPLE_BITS + 20;
    localparam int ACC_W  = tae_pkg::ACC_W;
    localparam int AW     = tae_pkg::ANGLE_W;

    logic signed [SAMPLE_BITS-1:0] x_reg, y_reg, z_reg;
    logic                          degen_reg;
    logic [SQ_W-1:0]               mul_reg;
    logic [SQ_W-1:0]               sum_reg;
    logic [RAD_W-1:0]              rad_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [ROOT_W-1:0]             root_reg;
    logic signed [VW-1:0]          vx_reg, vy_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [AW-1:0]          angle_reg [2];
    logic signed [AW-1:0]          store_reg [2];
    logic [tae_pkg::MAG_W-1:0]     mag_reg [2];
    logic                          neg_reg [2];
    logic [tae_pkg::PROD_W-1:0]    prod_reg [2];

    logic signed [AW-1:0]          pitch_out_reg, roll_out_reg;
    logic signed [AW-1:0]          pitch_sm_reg, roll_sm_reg;
    logic                          degen_out_reg;

    logic signed [SAMPLE_BITS-1:0] op_a;
    logic signed [SAMPLE_BITS:0]   num;
    logic signed [SAMPLE_BITS-1:0] mul_op;
    logic signed [SQ_W-1:0]        mul_full;
    logic [REM_W-1:0]              rem_sh;
    logic [REM_W-1:0]              trial;
    logic                          take;
    logic signed [VW-1:0]          dx, dy;
    logic signed [ACC_W-1:0]       atan_val;
    logic signed [ACC_W-1:0]       acc_rnd;
    logic signed [ACC_W-9:0]       q8;
    logic signed [AW-1:0]          angle_sat;

    assign stat.degen = degen_reg;

    // roll uses (y; x, z), pitch uses (-x; y, z)
    assign op_a   = cmd.sel_pitch ? y_reg : x_reg;
    assign num    = cmd.sel_pitch ? -{x_reg[SAMPLE_BITS-1], x_reg}
                                  : {y_reg[SAMPLE_BITS-1], y_reg};
    assign mul_op = cmd.sq_a ? op_a : z_reg;
    assign mul_full = mul_op * mul_op;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    assign dx       = vy_reg >>> cmd.iter;
    assign dy       = vx_reg >>> cmd.iter;
    assign atan_val = $signed({{(ACC_W - tae_pkg::ATAN_W){1'b0}},
                               tae_pkg::ATAN_Q16[cmd.iter]});

    assign acc_rnd = acc_reg + ACC_W'(128);
    assign q8      = acc_rnd[ACC_W-1:8];

    always_comb
    begin
        if (q8 > tae_pkg::ANGLE_MAX)
            angle_sat = AW'(tae_pkg::ANGLE_MAX);
        else if (q8 < tae_pkg::ANGLE_MIN)
            angle_sat = AW'(tae_pkg::ANGLE_MIN);
        else
            angle_sat = q8[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= accel_x;
            y_reg     <= accel_y;
            z_reg     <= accel_z;
            degen_reg <= (accel_z == '0) && ((accel_x == '0) || (accel_y == '0));
        end

        if (cmd.sq_a)
            mul_reg <= mul_full;
        if (cmd.sq_b)
        begin
            mul_reg <= mul_full;
            sum_reg <= mul_reg;
        end

        // radicand is (a^2 + b^2) * 2^32; take two bits a cycle
        if (cmd.sq_c)
        begin
            rad_reg  <= {sum_reg + mul_reg, 32'b0};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end

        if (cmd.cord_init)
        begin
            vx_reg  <= $signed({{(VW - ROOT_W){1'b0}}, root_reg});
            vy_reg  <= $signed({{(VW - SAMPLE_BITS - 17){num[SAMPLE_BITS]}}, num, 16'b0});
            acc_reg <= '0;
        end
        if (cmd.cord_step)
        begin
            if (!vy_reg[VW-1])
            begin
                vx_reg  <= vx_reg + dx;
                vy_reg  <= vy_reg - dy;
                acc_reg <= acc_reg + atan_val;
            end
            else
            begin
                vx_reg  <= vx_reg - dx;
                vy_reg  <= vy_reg + dy;
                acc_reg <= acc_reg - atan_val;
            end
        end

        if (cmd.load)
        begin
            angle_reg[tae_pkg::LANE_PITCH] <= '0;
            angle_reg[tae_pkg::LANE_ROLL]  <= '0;
        end
        else if (cmd.finish)
            angle_reg[cmd.sel_pitch ? tae_pkg::LANE_PITCH : tae_pkg::LANE_ROLL] <= angle_sat;

        if (cmd.out_load)
        begin
            pitch_out_reg <= angle_reg[tae_pkg::LANE_PITCH];
            roll_out_reg  <= angle_reg[tae_pkg::LANE_ROLL];
            pitch_sm_reg  <= store_reg[tae_pkg::LANE_PITCH];
            roll_sm_reg   <= store_reg[tae_pkg::LANE_ROLL];
            degen_out_reg <= degen_reg;
        end
    end

    // filter lanes: (9*old + new) / 10, rounded half away from zero,
    // divide by ten done as multiply by reciprocal and shift
    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic signed [tae_pkg::SUM_W-1:0] old_ext;
        logic signed [tae_pkg::SUM_W-1:0] cur_ext;
        logic signed [tae_pkg::SUM_W-1:0] s;
        logic [tae_pkg::SUM_W-1:0]        mag;
        logic [tae_pkg::SUM_W-1:0]        mag_rnd;
        logic [AW-1:0]                    q_mag;

        assign old_ext = tae_pkg::SUM_W'(store_reg[l]);
        assign cur_ext = tae_pkg::SUM_W'(angle_reg[l]);
        assign s       = (old_ext <<< 3) + old_ext + cur_ext;
        assign mag     = s[tae_pkg::SUM_W-1] ? -s : s;
        assign mag_rnd = mag + tae_pkg::SUM_W'(5);
        assign q_mag   = AW'(prod_reg[l][tae_pkg::PROD_W-1:tae_pkg::RECIP_SHIFT]);

        always_ff @(posedge clk)
        begin
            if (cmd.filt_a)
            begin
                mag_reg[l] <= mag_rnd[tae_pkg::MAG_W-1:0];
                neg_reg[l] <= s[tae_pkg::SUM_W-1];
            end
            if (cmd.filt_b)
                prod_reg[l] <= mag_reg[l] * tae_pkg::RECIP_TEN;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                store_reg[l] <= '0;
            else if (cmd.filt_c)
                store_reg[l] <= neg_reg[l] ? -$signed(q_mag) : $signed(q_mag);
        end
    end

    assign pitch_now      = pitch_out_reg;
    assign roll_now       = roll_out_reg;
    assign pitch_smoothed = pitch_sm_reg;
    assign roll_smoothed  = roll_sm_reg;
    assign degenerate     = degen_out_reg;

endmodule

`default_nettype wire

// ===== sv/tilt_angle_estimator.sv =====
// Tilt angle estimator: pitch and roll from one accelerometer sample, plus low-pass.
// A new sample is accepted only after the previous result has gone into the output registers;
// a degenerate sample skips the square root and CORDIC and goes straight to the filter lanes.
// Square root (two bits a cycle) and CORDIC unit are shared, run once for roll, once for pitch.
// Reset: asynchronous, clears the sequencer, output valid and both filter stores.
// Depends on tae_pkg, tae_sample_if, tae_angle_if, tae_ctrl, tae_dp.
`timescale 1ns / 1ps
`default_nettype none

module tilt_angle_estimator #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_BITS  = 13
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tae_sample_if.sink samples,
    tae_angle_if.source angles
);

    tae_pkg::cmd_t  cmd;
    tae_pkg::stat_t stat;

    tae_ctrl #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (angles.valid),
        .out_ready (angles.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tae_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .accel_x        (samples.accel_x),
        .accel_y        (samples.accel_y),
        .accel_z        (samples.accel_z),
        .pitch_now      (angles.pitch_now),
        .roll_now       (angles.roll_now),
        .pitch_smoothed (angles.pitch_smoothed),
        .roll_smoothed  (angles.roll_smoothed),
        .degenerate     (angles.degenerate)
    );

endmodule

`default_nettype wire

// ===== bench/tae_angle_checker.sv =====
// Scoreboard for the tilt angle estimator: watches both channels and checks each result item.
// Predicts pitch, roll and the smoothed stores itself.
// Depends on tae_pkg, tae_sample_if and tae_angle_if.
`timescale 1ns / 1ps
`default_nettype none

module tae_angle_checker #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_BITS  = 13
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tae_sample_if       samples,
    tae_angle_if        angles,
    output int unsigned failures,
    output int unsigned outstanding
);

    localparam int     TABLE_LEN   = 24;
    localparam int     STEPS       = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam longint ANGLE_LIMIT = 23040;

    // atan(2^-i) in degrees, Q16
    localparam longint ATAN_DEG_Q16 [TABLE_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668,   7334,    3667,   1833,   917,    458,    229,   115,
        57,      29,      14,     7,      4,      2,      1,     0
    };

    typedef logic signed [SAMPLE_BITS-1:0]      sample_t;
    typedef logic signed [tae_pkg::ANGLE_W-1:0] angle_t;

    typedef struct packed {
        angle_t pitch_now;
        angle_t roll_now;
        angle_t pitch_smoothed;
        angle_t roll_smoothed;
        logic   degenerate;
    } tilt_t;

    tilt_t  expected_angles [$];
    angle_t pitch_lp_store;
    angle_t roll_lp_store;

    function automatic longint unsigned isqrt_u64(longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // atan(num / sqrt(a^2 + b^2)) in Q8 degrees by CORDIC vectoring
    function automatic angle_t cordic_atan_q8(longint num, longint a, longint b);
        longint unsigned mag_sq;
        longint          vx;
        longint          vy;
        longint          dx;
        longint          dy;
        longint          acc;
        longint          q8;
        mag_sq = longint'(a * a + b * b);
        vx     = longint'(isqrt_u64(mag_sq << 32));
        vy     = num * 65536;
        acc    = 0;
        for (int i = 0; i < STEPS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx  = vx + dx;
                vy  = vy - dy;
                acc = acc + ATAN_DEG_Q16[i];
            end
            else
            begin
                vx  = vx - dx;
                vy  = vy + dy;
                acc = acc - ATAN_DEG_Q16[i];
            end
        end
        q8 = (acc + 128) >>> 8;
        if (q8 > ANGLE_LIMIT)
            q8 = ANGLE_LIMIT;
        else if (q8 < -ANGLE_LIMIT)
            q8 = -ANGLE_LIMIT;
        return angle_t'(q8);
    endfunction

    // (9*old + cur) / 10, ties away from zero
    function automatic angle_t lowpass_q8(angle_t old, angle_t cur);
        int          sum;
        int unsigned mag;
        int unsigned quo;
        sum = 9 * int'(old) + int'(cur);
        mag = (sum < 0) ? int'(-sum) : int'(sum);
        quo = (mag + 32'd5) / 32'd10;
        return (sum < 0) ? angle_t'(-int'(quo)) : angle_t'(int'(quo));
    endfunction

    function automatic tilt_t tilt_of_sample(sample_t x, sample_t y, sample_t z);
        longint sx;
        longint sy;
        longint sz;
        tilt_t  t;
        sx = longint'(x);
        sy = longint'(y);
        sz = longint'(z);
        t  = '0;
        // flat on a zero axis pair: no denominator, both angles forced to zero
        t.degenerate = (sz == 0) && (sx == 0 || sy == 0);
        if (!t.degenerate)
        begin
            t.roll_now  = cordic_atan_q8(sy, sx, sz);
            t.pitch_now = cordic_atan_q8(-sx, sy, sz);
        end
        return t;
    endfunction

    task automatic check_field(string field, int want, int got);
        if (want != got)
        begin
            $display("time %0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tilt_t want;
        if (!rst_n)
        begin
            pitch_lp_store = '0;
            roll_lp_store  = '0;
            expected_angles.delete();
            failures    = 0;
            outstanding = 0;
        end
        else
        begin
            if (samples.valid && samples.ready)
            begin
                want = tilt_of_sample(samples.accel_x, samples.accel_y, samples.accel_z);
                pitch_lp_store      = lowpass_q8(pitch_lp_store, want.pitch_now);
                roll_lp_store       = lowpass_q8(roll_lp_store, want.roll_now);
                want.pitch_smoothed = pitch_lp_store;
                want.roll_smoothed  = roll_lp_store;
                expected_angles.push_back(want);
            end
            if (angles.valid && angles.ready)
            begin
                if (expected_angles.size() == 0)
                begin
                    $display("time %0t: result item with none expected, expected nothing, actual %0d %0d %0d %0d %0d",
                             $time, angles.pitch_now, angles.roll_now, angles.pitch_smoothed,
                             angles.roll_smoothed, angles.degenerate);
                    failures++;
                end
                else
                begin
                    want = expected_angles.pop_front();
                    check_field("pitch_now", int'(want.pitch_now), int'(angles.pitch_now));
                    check_field("roll_now", int'(want.roll_now), int'(angles.roll_now));
                    check_field("pitch_smoothed", int'(want.pitch_smoothed),
                                int'(angles.pitch_smoothed));
                    check_field("roll_smoothed", int'(want.roll_smoothed),
                                int'(angles.roll_smoothed));
                    check_field("degenerate", int'(want.degenerate), int'(angles.degenerate));
                end
            end
            outstanding = expected_angles.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_tilt_angle_estimator.sv =====
// Top of the tilt angle estimator bench: clock, reset, sample stimulus and result backpressure.
// Depends on tae_pkg, tae_sample_if, tae_angle_if, tae_angle_checker and tilt_angle_estimator.
`timescale 1ns / 1ps
`default_nettype none

module tb_tilt_angle_estimator;

    localparam int SAMPLE_BITS  = 13;
    localparam int CORDIC_STEPS = 16;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CALM_ITEMS   = 200;
    localparam int LATENCY      = 2 * (SAMPLE_BITS + CORDIC_STEPS + 21) + 6;
    localparam int S_MIN        = -(1 << (SAMPLE_BITS - 1));
    localparam int S_MAX        = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int DIRECTED_LEN = 23;

    // x, y, z: extremes, zero-denominator cases, near-vertical overshoot, 45 degrees
    localparam int DIRECTED [DIRECTED_LEN][3] = '{
        '{S_MAX, S_MAX, S_MAX}, '{S_MIN, S_MIN, S_MIN}, '{S_MAX, S_MIN, S_MAX},
        '{S_MIN, S_MAX, S_MIN}, '{0, 0, 0},             '{S_MAX, 0, 0},
        '{0, S_MIN, 0},         '{1, 0, 0},             '{0, 1, 0},
        '{0, 0, S_MAX},         '{0, 0, S_MIN},         '{0, 0, 1},
        '{S_MAX, 1, 0},         '{1, S_MIN, 0},         '{0, S_MAX, 1},
        '{0, S_MIN, 1},         '{S_MIN, 0, 1},         '{S_MAX, 0, -1},
        '{1, 1, 0},             '{-1, -1, 1},           '{S_MIN, S_MIN, 0},
        '{2896, 0, 2896},       '{0, -1, -1}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        calm_tail;
    int unsigned failures;
    int unsigned outstanding;

    tae_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
    tae_angle_if                               angle_ch ();

    tilt_angle_estimator #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .angles  (angle_ch)
    );

    tae_angle_checker #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (sample_ch),
        .angles      (angle_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    initial
    begin
        #4ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int full_range();
        return int'($urandom_range(0, S_MAX - S_MIN)) + S_MIN;
    endfunction

    function automatic int near_zero(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int any_corner();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return S_MIN;
            2:       return S_MAX;
            3:       return near_zero(2);
            default: return full_range();
        endcase
    endfunction

    // Hold the item until taken, then maybe idle; called and returns at a falling edge.
    task automatic offer_sample(int x, int y, int z);
        int gap;
        int pick;
        sample_ch.accel_x <= SAMPLE_BITS'(x);
        sample_ch.accel_y <= SAMPLE_BITS'(y);
        sample_ch.accel_z <= SAMPLE_BITS'(z);
        sample_ch.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        @(negedge clk);
        pick = $urandom_range(0, 7);
        if (!calm_tail && pick < 3)
        begin
            gap = $urandom_range(1, 17);
            sample_ch.valid   <= 1'b0;
            sample_ch.accel_x <= SAMPLE_BITS'(full_range());
            sample_ch.accel_y <= SAMPLE_BITS'(full_range());
            sample_ch.accel_z <= SAMPLE_BITS'(full_range());
            // sometimes let the block go idle first so the gap shifts the next accept
            if (pick == 0)
            begin
                for (int n = 0; n < 2 * LATENCY && !sample_ch.ready; n++)
                    @(negedge clk);
            end
            repeat (gap) @(negedge clk);
        end
    endtask

    // result backpressure
    initial
    begin
        angle_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!calm_tail && $urandom_range(0, 2) == 0)
            begin
                angle_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            angle_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clk);
        end
    end

    initial
    begin
        int x;
        int y;
        int z;
        int axis;
        int lean;
        sample_ch.valid   = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        calm_tail         = 1'b0;
        rst_n             = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_LEN; i++)
            offer_sample(DIRECTED[i][0], DIRECTED[i][1], DIRECTED[i][2]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm_tail = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    x = full_range();
                    y = full_range();
                    z = full_range();
                end
                4, 5:
                begin
                    // gravity mostly along one axis
                    axis = $urandom_range(0, 2);
                    lean = $urandom_range(0, 1) ? int'($urandom_range(3000, S_MAX))
                                                : -int'($urandom_range(3000, -S_MIN));
                    x = (axis == 0) ? lean : near_zero(300);
                    y = (axis == 1) ? lean : near_zero(300);
                    z = (axis == 2) ? lean : near_zero(300);
                end
                6:
                begin
                    x = near_zero(3);
                    y = near_zero(3);
                    z = near_zero(3);
                end
                7:
                begin
                    x = $urandom_range(0, 2) ? full_range() : 0;
                    y = $urandom_range(0, 2) ? full_range() : 0;
                    z = 0;
                end
                default:
                begin
                    x = any_corner();
                    y = any_corner();
                    z = any_corner();
                end
            endcase
            offer_sample(x, y, z);
        end
        sample_ch.valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (LATENCY + 40) @(negedge clk);

        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
